// ===== rtl/fpba_pkg.sv =====
// Package for the fit-policy block allocator.
// Holds default sizes, register indexes, policy and action codes,
// controller state type and the command/status structs. No dependencies.
package fpba_pkg;

  // Default table geometry
  localparam int NUM_ENTRIES_DEF = 16;
  localparam int SIZE_BITS_DEF   = 16;

  // Fixed port widths
  localparam int ENTRY_W   = 4;
  localparam int REQ_W     = 16;
  localparam int GRANT_W   = 16;
  localparam int FRAG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;
  localparam int POLICY_W  = 2;
  localparam int BLOCKS_W  = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

  // Register reset values
  localparam logic [POLICY_W-1:0] FIT_POLICY_RST    = 2'd0;
  localparam logic [BLOCKS_W-1:0] BLOCKS_IN_USE_RST = 5'd16;

  // Fit policies; the unused code behaves as first fit
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  // Item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // Saturation limits
  localparam logic [GRANT_W-1:0] GRANT_MAX = '1;
  localparam logic [FRAG_W-1:0]  FRAG_MAX  = '1;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic do_load;   // write the table entry, clear totals
    logic rd_issue;  // read the entry under the scan pointer
    logic commit;    // apply the grant to table and totals
    logic out_load;  // move the result into the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_load;     // captured item is a load
    logic limit_zero;  // no entries to search
    logic scan_last;   // scan pointer is on the last entry
    logic out_free;    // output register can take a result
  } dp_stat_t;

endpackage

// ===== rtl/fpba_if.sv =====
// Handshake channels of the fit-policy block allocator: request items in,
// result items out. Depends on fpba_pkg for the field widths.
interface fpba_in_if import fpba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [ENTRY_W-1:0] entry_number;
  logic [REQ_W-1:0]   size_value;

  modport source (output valid, action, entry_number, size_value, input ready);
  modport sink   (input valid, action, entry_number, size_value, output ready);
endinterface

interface fpba_out_if import fpba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [ENTRY_W-1:0] chosen_entry;
  logic [REQ_W-1:0]   leftover;
  logic [GRANT_W-1:0] grants_so_far;
  logic [FRAG_W-1:0]  fragmentation_total;

  modport source (output valid, granted, chosen_entry, leftover, grants_so_far,
                  fragmentation_total, input ready);
  modport sink   (input valid, granted, chosen_entry, leftover, grants_so_far,
                  fragmentation_total, output ready);
endinterface

// ===== rtl/fpba_datapath.sv =====
// Datapath of the fit-policy block allocator: config registers, the
// free-size table, the scan/compare stage, totals and output register.
// Depends on fpba_pkg; driven by fpba_controller commands.
module fpba_datapath import fpba_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // captured request fields
  input  logic                 action,
  input  logic [ENTRY_W-1:0]   entry_number,
  input  logic [REQ_W-1:0]     size_value,
  // configuration writes
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // control
  input  ctl_cmd_t             cmd,
  output dp_stat_t             stat,
  // result register
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 granted,
  output logic [ENTRY_W-1:0]   chosen_entry,
  output logic [REQ_W-1:0]     leftover,
  output logic [GRANT_W-1:0]   grants_so_far,
  output logic [FRAG_W-1:0]    fragmentation_total
);

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

  // Configuration registers
  logic [POLICY_W-1:0] fit_policy;
  logic [BLOCKS_W-1:0] blocks_in_use;

  // Captured item
  logic                 action_r;
  logic [ENTRY_W-1:0]   entry_r;
  logic [SIZE_BITS-1:0] req_r;
  logic [CNT_W-1:0]     limit_r;
  logic [CNT_W-1:0]     limit_next;

  // Table
  logic [SIZE_BITS-1:0] mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] vld;
  logic [SIZE_BITS-1:0] rd_data;
  logic                 rd_vld;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [SIZE_BITS-1:0] wr_data;

  // Scan and compare
  logic [IDX_W-1:0]     scan_idx;
  logic                 cmp_en;
  logic [IDX_W-1:0]     cmp_idx;
  logic [SIZE_BITS-1:0] cmp_sz;
  logic [SIZE_BITS-1:0] cmp_rest;
  logic                 cmp_fits;
  logic                 cmp_take;
  logic                 have_pick;
  logic [IDX_W-1:0]     pick_idx;
  logic [SIZE_BITS-1:0] pick_sz;
  logic [SIZE_BITS-1:0] best_val;

  // Commit and totals
  logic [SIZE_BITS-1:0] commit_rest;
  logic [SIZE_BITS-1:0] rest_r;
  logic [GRANT_W-1:0]   grant_count;
  logic [FRAG_W-1:0]    fragment_sum;
  logic [FRAG_W:0]      frag_add;
  logic                 load_in_range;

  // Configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy    <= FIT_POLICY_RST;
      blocks_in_use <= BLOCKS_IN_USE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FIT_POLICY:    fit_policy    <= cfg_data[POLICY_W-1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[BLOCKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Entries searched, clamped to the table depth
  always_comb begin
    if (32'(blocks_in_use) > NUM_ENTRIES) limit_next = CNT_W'(NUM_ENTRIES);
    else                                  limit_next = CNT_W'(blocks_in_use);
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r <= action;
      entry_r  <= entry_number;
      req_r    <= SIZE_BITS'(size_value);
      limit_r  <= limit_next;
    end
  end

  // Scan pointer
  always_ff @(posedge clk) begin
    if (cmd.capture)       scan_idx <= '0;
    else if (cmd.rd_issue) scan_idx <= scan_idx + IDX_W'(1);
  end

  assign load_in_range = 32'(entry_r) < NUM_ENTRIES;

  // Table write: load or grant
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = pick_idx;
    wr_data = commit_rest;
    if (cmd.do_load) begin
      wr_en   = load_in_range;
      wr_idx  = IDX_W'(entry_r);
      wr_data = req_r;
    end else if (cmd.commit) begin
      wr_en = have_pick;
    end
  end

  // Table storage with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    rd_data <= mem[scan_idx];
  end

  // Written flags; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) vld[wr_idx] <= 1'b1;
      rd_vld <= vld[scan_idx];
    end
  end

  // Compare stage works on the read data in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) cmp_en <= 1'b0;
    else     cmp_en <= cmd.rd_issue;
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
  end

  assign cmp_sz   = rd_vld ? rd_data : '0;
  assign cmp_fits = cmp_sz >= req_r;
  assign cmp_rest = cmp_sz - req_r;

  // Policy decision; ties keep the earlier entry
  always_comb begin
    case (fit_policy)
      POL_BEST:  cmp_take = cmp_fits && (!have_pick || cmp_rest < best_val);
      POL_WORST: cmp_take = cmp_fits && (!have_pick || cmp_sz > best_val);
      default:   cmp_take = cmp_fits && !have_pick;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      have_pick <= 1'b0;
    end else if (cmp_en && cmp_take) begin
      have_pick <= 1'b1;
      pick_idx  <= cmp_idx;
      pick_sz   <= cmp_sz;
      best_val  <= (fit_policy == POL_BEST) ? cmp_rest : cmp_sz;
    end
  end

  // Grant commit and saturating totals
  assign commit_rest = pick_sz - req_r;
  assign frag_add    = {1'b0, fragment_sum} + (FRAG_W + 1)'(commit_rest);

  always_ff @(posedge clk) begin
    if (cmd.commit) rest_r <= commit_rest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grant_count  <= '0;
      fragment_sum <= '0;
    end else if (cmd.do_load) begin
      grant_count  <= '0;
      fragment_sum <= '0;
    end else if (cmd.commit && have_pick) begin
      if (grant_count != GRANT_MAX) grant_count <= grant_count + GRANT_W'(1);
      fragment_sum <= frag_add[FRAG_W] ? FRAG_MAX : frag_add[FRAG_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready)    out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      granted             <= have_pick;
      chosen_entry        <= have_pick ? ENTRY_W'(pick_idx) : '0;
      leftover            <= have_pick ? REQ_W'(rest_r) : '0;
      grants_so_far       <= grant_count;
      fragmentation_total <= fragment_sum;
    end
  end

  // Status to the controller
  assign stat.is_load    = (action_r == ACT_LOAD);
  assign stat.limit_zero = (limit_r == '0);
  assign stat.scan_last  = (CNT_W'(scan_idx) + CNT_W'(1)) == limit_r;
  assign stat.out_free   = !out_valid || out_ready;

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten while held");

  // A denied result carries no entry or leftover
  a_denied_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (chosen_entry == '0 && leftover == '0))
    else $error("denied result carries entry data");

  // Reads stay inside the searched range
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (CNT_W'(scan_idx) < limit_r))
    else $error("scan read beyond entries in use");

endmodule

// ===== rtl/fpba_controller.sv =====
// Controller of the fit-policy block allocator: sequences capture, load,
// scan, grant commit and result hand-off. Depends on fpba_pkg.
module fpba_controller import fpba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        if (stat.is_load)         state_next = S_LOAD;
        else if (stat.limit_zero) state_next = S_UPDATE;
        else                      state_next = S_SCAN;
      end
      S_LOAD:     state_next = S_FINISH;
      S_SCAN:     if (stat.scan_last) state_next = S_DRAIN;
      S_DRAIN:    state_next = S_UPDATE;
      S_UPDATE:   state_next = S_FINISH;
      S_FINISH:   if (stat.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_LOAD:   cmd.do_load  = 1'b1;
      S_SCAN:   cmd.rd_issue = 1'b1;
      S_UPDATE: cmd.commit   = 1'b1;
      S_FINISH: cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

  // An accepted item is dispatched next cycle
  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISPATCH))
    else $error("accepted item not dispatched");

  // Scan runs until the last entry is read
  a_scan_continues: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_issue && !stat.scan_last) |=> cmd.rd_issue)
    else $error("scan stopped early");

  // Handing off the result frees the block for the next item
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (state == S_IDLE))
    else $error("block not idle after result hand-off");

endmodule

// ===== rtl/fit_policy_block_allocator.sv =====
// Fit-policy block allocator, top level. Depends on fpba_pkg, fpba_if,
// fpba_controller and fpba_datapath.
// A load passes through dispatch, load and finish; an allocate passes through
// dispatch, a scan over blocks_in_use entries (clamped to NUM_ENTRIES) that
// reads one table entry per cycle from one read port, a drain, the grant update
// and finish, and skips the scan when no entry is searched. One item is worked
// on at a time; the next is accepted while a result waits.
// Reset (rst, synchronous): table reads as zero, totals zero, policy first fit.
module fit_policy_block_allocator import fpba_pkg::*; #(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int SIZE_BITS   = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  fpba_in_if.sink              items,
  fpba_out_if.source           results,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencer
  fpba_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table, search and result path
  fpba_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .SIZE_BITS   (SIZE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .action              (items.action),
    .entry_number        (items.entry_number),
    .size_value          (items.size_value),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (results.valid),
    .out_ready           (results.ready),
    .granted             (results.granted),
    .chosen_entry        (results.chosen_entry),
    .leftover            (results.leftover),
    .grants_so_far       (results.grants_so_far),
    .fragmentation_total (results.fragmentation_total)
  );

endmodule

// ===== verif/alloc_check_pkg.sv =====
// Result type and in-order checker for the fit-policy block allocator bench.
// Keeps a shadow copy of the partition table, totals and registers.
// Depends on fpba_pkg.
package alloc_check_pkg;
  import fpba_pkg::*;

  // Policy code with no name in the design package; behaves as first fit
  localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic               granted;
    logic [ENTRY_W-1:0] chosen_entry;
    logic [REQ_W-1:0]   leftover;
    logic [GRANT_W-1:0] grants_so_far;
    logic [FRAG_W-1:0]  fragmentation_total;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [REQ_W-1:0]    free_size [NUM_ENTRIES_DEF];
    logic [GRANT_W-1:0]  grant_count;
    logic [FRAG_W-1:0]   fragment_sum;
    logic [POLICY_W-1:0] policy;
    logic [BLOCKS_W-1:0] blocks_in_use;
    alloc_result_t       predicted_results [$];
    int unsigned         errors;

    function new();
      foreach (free_size[i]) free_size[i] = '0;
      grant_count   = '0;
      fragment_sum  = '0;
      policy        = FIT_POLICY_RST;
      blocks_in_use = BLOCKS_IN_USE_RST;
      errors        = 0;
    endfunction

    // Register write; unknown indexes change nothing
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == REG_FIT_POLICY) begin
        policy = data[POLICY_W-1:0];
      end else if (idx == REG_BLOCKS_IN_USE) begin
        blocks_in_use = data[BLOCKS_W-1:0];
      end
    endfunction

    // Entry picked for a request under the current policy, -1 if none fits
    function int find_fit(logic [REQ_W-1:0] req);
      int               lim;
      int               pick;
      logic [REQ_W-1:0] best;
      logic [REQ_W-1:0] rest;
      lim  = (blocks_in_use > NUM_ENTRIES_DEF) ? NUM_ENTRIES_DEF : int'(blocks_in_use);
      pick = -1;
      best = '0;
      for (int i = 0; i < lim; i++) begin
        if (free_size[i] < req) continue;
        rest = free_size[i] - req;
        if (policy == POL_BEST) begin
          // strict compare keeps the lowest index on ties
          if (pick < 0 || rest < best) begin
            best = rest;
            pick = i;
          end
        end else if (policy == POL_WORST) begin
          if (pick < 0 || free_size[i] > best) begin
            best = free_size[i];
            pick = i;
          end
        end else begin
          return i;
        end
      end
      return pick;
    endfunction

    // Apply an accepted item to the shadow state and queue its result
    function void apply_item(logic act, logic [ENTRY_W-1:0] ent, logic [REQ_W-1:0] sz);
      alloc_result_t    r;
      int               k;
      logic [REQ_W-1:0] rest;
      logic [FRAG_W:0]  sum;
      r = '0;
      if (act == ACT_LOAD) begin
        free_size[ent] = sz;
        grant_count    = '0;
        fragment_sum   = '0;
      end else begin
        k = find_fit(sz);
        if (k >= 0) begin
          rest           = free_size[k] - sz;
          free_size[k]   = rest;
          r.granted      = 1'b1;
          r.chosen_entry = k[ENTRY_W-1:0];
          r.leftover     = rest;
          if (grant_count != GRANT_MAX) grant_count++;
          sum          = {1'b0, fragment_sum} + rest;
          fragment_sum = sum[FRAG_W] ? FRAG_MAX : sum[FRAG_W-1:0];
        end
      end
      r.grants_so_far       = grant_count;
      r.fragmentation_total = fragment_sum;
      predicted_results.push_back(r);
    endfunction

    // Compare one result item with the oldest prediction
    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (predicted_results.size() == 0) begin
        $error("result item arrived with nothing expected");
        errors++;
        return;
      end
      want = predicted_results.pop_front();
      if (got.granted !== want.granted) begin
        $error("granted: expected %0d, got %0d", want.granted, got.granted);
        errors++;
      end
      if (got.chosen_entry !== want.chosen_entry) begin
        $error("chosen_entry: expected %0d, got %0d", want.chosen_entry, got.chosen_entry);
        errors++;
      end
      if (got.leftover !== want.leftover) begin
        $error("leftover: expected %0d, got %0d", want.leftover, got.leftover);
        errors++;
      end
      if (got.grants_so_far !== want.grants_so_far) begin
        $error("grants_so_far: expected %0d, got %0d", want.grants_so_far,
               got.grants_so_far);
        errors++;
      end
      if (got.fragmentation_total !== want.fragmentation_total) begin
        $error("fragmentation_total: expected %0d, got %0d", want.fragmentation_total,
               got.fragmentation_total);
        errors++;
      end
    endfunction

    function int outstanding();
      return predicted_results.size();
    endfunction
  endclass

endpackage

// ===== verif/testbench.sv =====
// Top-level bench for fit_policy_block_allocator: directed and random items,
// register phases and a long output stall.
// Depends on fpba_pkg, fpba_if, the allocator RTL and alloc_check_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fpba_pkg::*;
  import alloc_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200_000;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 116;
  localparam int unsigned HOLD_AT_RESULT  = 200;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 30;

  localparam logic [POLICY_W-1:0] PHASE_POLICY [NUM_PHASES] = '{
    POL_FIRST, POL_BEST, POL_WORST, POL_SPARE, POL_BEST, POL_WORST, POL_FIRST, POL_BEST
  };
  localparam logic [BLOCKS_W-1:0] PHASE_BLOCKS [NUM_PHASES] = '{
    5'd16, 5'd5, 5'd1, 5'd31, 5'd16, 5'd0, 5'd9, 5'd17
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  bit                   no_gaps;
  int unsigned          results_seen;
  int unsigned          cycle_count;

  alloc_scoreboard ledger = new();

  fpba_in_if  items_ch();
  fpba_out_if results_ch();

  fit_policy_block_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_ch),
    .results   (results_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one item after a random gap; returns at the falling edge after accept
  task automatic send_item(input logic act, input logic [ENTRY_W-1:0] ent,
                           input logic [REQ_W-1:0] sz);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      items_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_ch.valid        = 1'b1;
    items_ch.action       = act;
    items_ch.entry_number = ent;
    items_ch.size_value   = sz;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    ledger.apply_item(act, ent, sz);
    @(negedge clk);
  endtask

  // Register write once every predicted result has come back
  task automatic write_when_idle(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DAT_W-1:0] data);
    items_ch.valid = 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = data;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    ledger.write_reg(idx, data);
  endtask

  // Result side: random stalls, one long hold-off, in-order check
  initial begin : result_sink
    int unsigned   stall;
    alloc_result_t got;
    results_ch.ready = 1'b0;
    results_seen     = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (results_seen == HOLD_AT_RESULT) stall = HOLD_CYCLES;
      if (stall != 0) begin
        results_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      results_ch.ready = 1'b1;
      @(posedge clk);
      while (!results_ch.valid) @(posedge clk);
      got.granted             = results_ch.granted;
      got.chosen_entry        = results_ch.chosen_entry;
      got.leftover            = results_ch.leftover;
      got.grants_so_far       = results_ch.grants_so_far;
      got.fragmentation_total = results_ch.fragmentation_total;
      ledger.check_result(got);
      results_seen++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [ENTRY_W-1:0]  ent;
    logic [REQ_W-1:0]    sz;
    logic [CFG_DAT_W-1:0] blocks;

    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    items_ch.valid        = 1'b0;
    items_ch.action       = ACT_LOAD;
    items_ch.entry_number = '0;
    items_ch.size_value   = '0;
    no_gaps               = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty table, zero request fits a zero-size entry
    send_item(ACT_ALLOC, 4'd15, '0);
    send_item(ACT_ALLOC, 4'd0, 16'd1);
    send_item(ACT_LOAD, 4'd0, 16'd100);
    send_item(ACT_LOAD, 4'd15, '1);
    send_item(ACT_LOAD, 4'd7, 16'd300);
    send_item(ACT_LOAD, 4'd3, 16'd100);
    send_item(ACT_ALLOC, 4'd9, '1);
    send_item(ACT_ALLOC, 4'd6, 16'd50);
    // best fit: exact match, then smallest leftover
    write_when_idle(REG_FIT_POLICY, POL_BEST);
    send_item(ACT_ALLOC, 4'd1, 16'd100);
    send_item(ACT_ALLOC, 4'd2, 16'd40);
    // worst fit, then a tie on the largest entry
    write_when_idle(REG_FIT_POLICY, POL_WORST);
    send_item(ACT_ALLOC, 4'd4, 16'd10);
    send_item(ACT_LOAD, 4'd5, 16'd290);
    send_item(ACT_ALLOC, 4'd8, '0);
    // unused policy code acts as first fit
    write_when_idle(REG_FIT_POLICY, POL_SPARE);
    send_item(ACT_ALLOC, 4'd10, 16'd5);
    // no entries searched
    write_when_idle(REG_BLOCKS_IN_USE, 5'd0);
    send_item(ACT_ALLOC, 4'd11, '0);
    // single entry
    write_when_idle(REG_BLOCKS_IN_USE, 5'd1);
    send_item(ACT_ALLOC, 4'd12, 16'd6);
    send_item(ACT_ALLOC, 4'd13, 16'd5);
    // count above the table size is clamped
    write_when_idle(REG_BLOCKS_IN_USE, 5'd31);
    send_item(ACT_ALLOC, 4'd14, '1);
    send_item(ACT_ALLOC, 4'd0, 16'd1);
    // writes to unused indexes change nothing
    write_when_idle(REG_SPARE_A, 5'd31);
    write_when_idle(REG_SPARE_B, 5'd0);
    send_item(ACT_ALLOC, 4'd15, 16'd1);

    // Random phases, each opening with a full table load
    for (int p = 0; p < NUM_PHASES; p++) begin
      blocks = (p == 6) ? CFG_DAT_W'($urandom_range(1, NUM_ENTRIES_DEF)) : PHASE_BLOCKS[p];
      write_when_idle(REG_FIT_POLICY, PHASE_POLICY[p]);
      write_when_idle(REG_BLOCKS_IN_USE, blocks);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        ent = ENTRY_W'($urandom);
        sz  = REQ_W'($urandom);
        if (n < NUM_ENTRIES_DEF) begin
          if ($urandom_range(0, 3) == 0) sz = REQ_W'($urandom_range(0, 1023));
          send_item(ACT_LOAD, ENTRY_W'(n), sz);
        end else if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 7) == 0) sz = $urandom_range(0, 1) ? '0 : '1;
          send_item(ACT_LOAD, ent, sz);
        end else begin
          case ($urandom_range(0, 3))
            0: sz = REQ_W'($urandom_range(0, 255));
            1: sz = ledger.free_size[$urandom_range(0, NUM_ENTRIES_DEF - 1)];
            2: sz = REQ_W'($urandom_range(0, 16383));
            default: ;
          endcase
          send_item(ACT_ALLOC, ent, sz);
        end
      end
    end

    // Drain and finish
    items_ch.valid = 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
